>>> rtl/core/utd_pkg.sv
package utd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_UCS2_LE = 2'd0;
  localparam logic [1:0] MODE_UCS2_BE = 2'd1;
  localparam logic [1:0] MODE_UTF8    = 2'd2;

  localparam logic [7:0]  BOM8_0     = 8'hEF;
  localparam logic [7:0]  BOM8_1     = 8'hBB;
  localparam logic [7:0]  BOM8_2     = 8'hBF;
  localparam logic [15:0] UNIT_MARK  = 16'hFEFF;
  localparam logic [15:0] UNIT_QUERY = 16'h003F;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2,
    KIND_SKIP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_ASCII   = 3'd0,
    OP_PAIR_LE = 3'd1,
    OP_PAIR_BE = 3'd2,
    OP_TWO     = 3'd3,
    OP_THREE   = 3'd4,
    OP_QUERY   = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] lead;
    logic [7:0] second;
    logic [7:0] data;
  } rec_t;

  typedef struct packed {
    logic           full;
    logic           valid;
    logic [QCW-1:0] count;
  } qstat_t;

endpackage

>>> rtl/core/utd_front.sv
module utd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       mode,
  input  logic             cfg_clear,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             stream_start,
  input  logic             stream_end,
  output logic             push,
  output utd_pkg::rec_t    push_rec
);

  logic [7:0]      lead_r, lead_nxt;
  logic [7:0]      second_r, second_nxt;
  logic [2:0]      need_r, need_nxt;
  utd_pkg::kind_t  kind_r, kind_nxt;
  logic [1:0]      pos_r, pos_nxt;
  logic            at_start_r, at_start_nxt;

  logic [2:0]      need_e;
  logic [2:0]      need_dec;
  utd_pkg::kind_t  kind_e;
  logic            at_start_e;
  logic            first;
  logic            is_ucs2;
  logic            big;
  logic            emit;
  utd_pkg::op_t    op;
  logic            clr;

  always_comb begin
    need_e     = stream_start ? 3'd0 : need_r;
    kind_e     = stream_start ? utd_pkg::KIND_NONE : kind_r;
    at_start_e = stream_start ? 1'b0 : at_start_r;
    first      = stream_start || (pos_r == 2'd0);
    pos_nxt    = pos_r;
    if (stream_start) begin
      pos_nxt = 2'd1;
    end else if (pos_r != 2'd3) begin
      pos_nxt = pos_r + 2'd1;
    end
    need_dec     = need_e - 3'd1;
    is_ucs2      = (mode == utd_pkg::MODE_UCS2_LE) || (mode == utd_pkg::MODE_UCS2_BE);
    big          = (mode == utd_pkg::MODE_UCS2_BE);
    lead_nxt     = lead_r;
    second_nxt   = second_r;
    need_nxt     = need_e;
    kind_nxt     = kind_e;
    at_start_nxt = at_start_e;
    emit         = 1'b0;
    op           = utd_pkg::OP_ASCII;
    clr          = 1'b0;

    if (is_ucs2) begin
      if (need_e == 3'd0) begin
        lead_nxt     = data_byte;
        need_nxt     = 3'd1;
        kind_nxt     = utd_pkg::KIND_NONE;
        at_start_nxt = first;
      end else begin
        clr  = 1'b1;
        op   = big ? utd_pkg::OP_PAIR_BE : utd_pkg::OP_PAIR_LE;
        // drop a byte-order mark that opens the stream
        emit = !(at_start_e && (big ?
                 ({lead_r, data_byte} == utd_pkg::UNIT_MARK) :
                 ({data_byte, lead_r} == utd_pkg::UNIT_MARK)));
      end
    end else if (need_e == 3'd0) begin
      if (!data_byte[7]) begin
        emit = 1'b1;
        op   = utd_pkg::OP_ASCII;
      end else begin
        lead_nxt     = data_byte;
        at_start_nxt = first;
        priority if (!data_byte[5]) begin
          kind_nxt = utd_pkg::KIND_TWO;
          need_nxt = 3'd1;
        end else if (!data_byte[4]) begin
          kind_nxt = utd_pkg::KIND_THREE;
          need_nxt = 3'd2;
        end else if (!data_byte[3]) begin
          kind_nxt = utd_pkg::KIND_SKIP;
          need_nxt = 3'd3;
        end else if (!data_byte[2]) begin
          kind_nxt = utd_pkg::KIND_SKIP;
          need_nxt = 3'd4;
        end else if (!data_byte[1]) begin
          kind_nxt = utd_pkg::KIND_SKIP;
          need_nxt = 3'd5;
        end else begin
          clr  = 1'b1;
          emit = 1'b1;
          op   = utd_pkg::OP_QUERY;
        end
      end
    end else begin
      need_nxt = need_dec;
      unique case (kind_e)
        utd_pkg::KIND_TWO: begin
          clr  = 1'b1;
          emit = 1'b1;
          op   = utd_pkg::OP_TWO;
        end
        utd_pkg::KIND_THREE: begin
          if (need_dec != 3'd0) begin
            second_nxt = data_byte;
          end else begin
            clr  = 1'b1;
            op   = utd_pkg::OP_THREE;
            emit = !(at_start_e && lead_r == utd_pkg::BOM8_0 &&
                     second_r == utd_pkg::BOM8_1 && data_byte == utd_pkg::BOM8_2);
          end
        end
        utd_pkg::KIND_SKIP: begin
          if (need_dec == 3'd0) begin
            clr  = 1'b1;
            emit = 1'b1;
            op   = utd_pkg::OP_QUERY;
          end
        end
        default: begin
          if (need_dec == 3'd0) begin
            clr = 1'b1;
          end
        end
      endcase
    end

    if (clr || stream_end) begin
      need_nxt     = 3'd0;
      kind_nxt     = utd_pkg::KIND_NONE;
      at_start_nxt = 1'b0;
    end
  end

  assign push            = accept && emit;
  assign push_rec.op     = op;
  assign push_rec.lead   = lead_r;
  assign push_rec.second = second_r;
  assign push_rec.data   = data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r     <= 3'd0;
      kind_r     <= utd_pkg::KIND_NONE;
      pos_r      <= 2'd0;
      at_start_r <= 1'b0;
    end else if (cfg_clear) begin
      need_r     <= 3'd0;
      kind_r     <= utd_pkg::KIND_NONE;
      at_start_r <= 1'b0;
    end else if (accept) begin
      need_r     <= need_nxt;
      kind_r     <= kind_nxt;
      pos_r      <= pos_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

>>> rtl/core/utd_queue.sv
module utd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utd_pkg::rec_t   push_rec,
  input  logic            pop,
  output utd_pkg::rec_t   pop_rec,
  output utd_pkg::qstat_t stat
);

  utd_pkg::rec_t                 mem_r [utd_pkg::QDEPTH];
  logic [utd_pkg::QAW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [utd_pkg::QAW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [utd_pkg::QCW-1:0]       count_r, count_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign stat.full  = (count_r == utd_pkg::QCW'(utd_pkg::QDEPTH));
  assign stat.valid = (count_r != '0);
  assign stat.count = count_r;
  assign pop_rec    = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !stat.full;
    do_pop     = pop && stat.valid;
    wr_ptr_nxt = wr_ptr_r + (do_push ? utd_pkg::QAW'(1) : '0);
    rd_ptr_nxt = rd_ptr_r + (do_pop ? utd_pkg::QAW'(1) : '0);
    count_nxt  = count_r + (do_push ? utd_pkg::QCW'(1) : '0)
                         - (do_pop ? utd_pkg::QCW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

>>> rtl/core/utd_back.sv
module utd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  utd_pkg::qstat_t qstat,
  input  utd_pkg::rec_t   rec,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [15:0]     out_code_unit
);

  logic        valid_r, valid_nxt;
  logic [15:0] unit_r;
  logic [15:0] unit_nxt;

  always_comb begin
    unique case (rec.op)
      utd_pkg::OP_ASCII:   unit_nxt = {8'h00, rec.data};
      utd_pkg::OP_PAIR_LE: unit_nxt = {rec.data, rec.lead};
      utd_pkg::OP_PAIR_BE: unit_nxt = {rec.lead, rec.data};
      utd_pkg::OP_TWO:     unit_nxt = {5'b0, rec.lead[4:0], rec.data[5:0]};
      utd_pkg::OP_THREE:   unit_nxt = {rec.lead[3:0], rec.second[5:0], rec.data[5:0]};
      default:             unit_nxt = utd_pkg::UNIT_QUERY;
    endcase
  end

  // load a new unit whenever the output register is empty or being taken
  assign pop = qstat.valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unit_r <= unit_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_code_unit = unit_r;

endmodule

>>> rtl/core/utf8_ucs2_text_decoder.sv
// Byte stream decoder, UTF-8 or UCS-2 LE/BE in, 16-bit code units out.
// Throughput: one byte per cycle while the queue is not full (in_stall low); the
// front decodes a byte in the cycle it is taken and a four-entry queue decouples it
// from the output register. With the queue empty, a unit's last byte is queued,
// then loaded into the output register. Reset (synchronous, rst_n low): mode UTF-8,
// no pending sequence, stream position zero, queue and output register empty.
module utf8_ucs2_text_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_start,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic            [1:0] mode_r;
  logic                  cfg_wr;
  logic                  accept;
  logic                  push;
  logic                  pop;
  utd_pkg::rec_t         push_rec;
  utd_pkg::rec_t         pop_rec;
  utd_pkg::qstat_t       qstat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && !paddr[2];
  assign prdata   = paddr[2] ? 32'd0 : {30'd0, mode_r};
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= utd_pkg::MODE_UTF8;
    end else if (cfg_wr) begin
      mode_r <= pwdata[1:0];
    end
  end

  utd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .cfg_clear    (cfg_wr),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .stream_start (in_stream_start),
    .stream_end   (in_stream_end),
    .push         (push),
    .push_rec     (push_rec)
  );

  utd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .stat     (qstat)
  );

  utd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .qstat         (qstat),
    .rec           (pop_rec),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_unit (out_code_unit)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= utd_pkg::QCW'(utd_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (qstat.valid && (!out_valid || !out_stall)))
    else $error("queue popped while output register held");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && qstat.full) |-> !accept)
    else $error("transfer accepted into a full queue");

  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (mode_r == $past(pwdata[1:0])))
    else $error("mode register not written");
`endif

endmodule
